@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASRT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASRT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pdwv_pkg.sv @@
// ----------------------------------------------------------------------------
// PD wheel velocity controller package
// Shared types, command and status structs, constants and helpers.
// ----------------------------------------------------------------------------
package pdwv_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FRACTION = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SETPOINT = 8'd3;

    // Arithmetic constants
    localparam logic [31:0] MIN_STEP_US = 32'd100;
    localparam logic [31:0] US_PER_S    = 32'd1000000;

    // Divider sizing: two quotient bits per step
    localparam int          DIV_PAIRS_W = 6;
    localparam logic [DIV_PAIRS_W-1:0] RATE_PAIRS = 6'd18;
    localparam logic [DIV_PAIRS_W-1:0] INC_PAIRS  = 6'd32;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_PROP,
        MUL_DIFF,
        MUL_DERIV,
        MUL_TORQUE,
        MUL_DECAY
    } mul_op_t;

    // Divider operand selection
    typedef enum logic {
        DIV_RATE,
        DIV_INC
    } div_op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_PROP,
        ST_MUL_DIFF,
        ST_DIV_RATE,
        ST_WAIT_RATE,
        ST_MUL_DERIV,
        ST_SUM,
        ST_MUL_TORQUE,
        ST_DIV_INC,
        ST_WAIT_INC,
        ST_ACC,
        ST_MUL_DECAY,
        ST_COMMIT,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_in;
        logic    eval_step;
        mul_op_t mul_op;
        logic    save_prop;
        logic    div_start;
        div_op_t div_op;
        logic    sum_torque;
        logic    acc_vel;
        logic    commit;
        logic    load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic step_big;
        logic div_busy;
    } status_t;

    // Clamp a 50-bit signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic fits;
        begin
            fits = (v[49:31] == {19{1'b0}}) || (v[49:31] == {19{1'b1}});
            if (fits)
                sat32 = v[31:0];
            else if (v[49])
                sat32 = 32'sh8000_0000;
            else
                sat32 = 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

@@ hw/rtl/pdwv_div.sv @@
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, two quotient
// bits per cycle, for a selectable number of steps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdwv_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [63:0]                     dividend,
    input  logic [31:0]                     divisor,
    input  logic [pdwv_pkg::DIV_PAIRS_W-1:0] pairs,
    output logic                            busy,
    output logic [63:0]                     quotient
);
    import pdwv_pkg::*;

    logic [63:0]            num_reg;
    logic [63:0]            num_next;
    logic [31:0]            rem_reg;
    logic [31:0]            rem_next;
    logic [31:0]            den_reg;
    logic [DIV_PAIRS_W-1:0] cnt_reg;
    logic [DIV_PAIRS_W-1:0] cnt_next;
    logic                   busy_reg;
    logic                   busy_next;

    logic [32:0] trial1;
    logic [32:0] trial2;
    logic        ge1;
    logic        ge2;
    logic [31:0] rem1;
    logic [63:0] num1;

    // Two restoring steps per cycle
    always_comb
    begin
        trial1 = {rem_reg, num_reg[63]};
        ge1    = trial1 >= {1'b0, den_reg};
        rem1   = ge1 ? 32'(trial1 - {1'b0, den_reg}) : trial1[31:0];
        num1   = {num_reg[62:0], ge1};

        trial2 = {rem1, num1[63]};
        ge2    = trial2 >= {1'b0, den_reg};
        rem_next = ge2 ? 32'(trial2 - {1'b0, den_reg}) : trial2[31:0];
        num_next = {num1[62:0], ge2};

        cnt_next  = cnt_reg - 1'b1;
        busy_next = (cnt_reg != {{(DIV_PAIRS_W-1){1'b0}}, 1'b1});
    end

    // Control: step count and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= pairs;
            busy_reg <= (pairs != '0);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;

    `ASRT_ALWAYS(a_no_restart, start |-> !busy_reg, "divider started while busy")

endmodule

@@ hw/rtl/pdwv_dp.sv @@
// ----------------------------------------------------------------------------
// PD controller datapath
// Configuration registers, controller state, one shared signed multiplier,
// the iterative divider and the output word register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdwv_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pdwv_pkg::cmd_t                   cmd,
    output pdwv_pkg::status_t                status,
    input  logic                             cfg_we,
    input  logic [pdwv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdwv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [15:0]               tilt_angle,
    input  logic [31:0]                      timestamp_us,
    output logic signed [31:0]               wheel_velocity,
    output logic                             updated
);
    import pdwv_pkg::*;

    // Configuration
    logic signed [15:0] prop_gain_reg;
    logic signed [15:0] deriv_gain_reg;
    logic        [15:0] decay_fraction_reg;
    logic signed [15:0] angle_setpoint_reg;

    // Controller state
    logic signed [15:0] prev_angle_reg;
    logic        [31:0] prev_time_reg;
    logic signed [31:0] velocity_acc_reg;

    // Working registers
    logic signed [15:0] angle_reg;
    logic        [31:0] now_reg;
    logic        [31:0] step_reg;
    logic               upd_reg;
    logic signed [65:0] prod_reg;
    logic signed [32:0] tq_p_reg;
    logic signed [31:0] torque_reg;
    logic signed [31:0] vel_reg;
    logic signed [31:0] wheel_velocity_reg;
    logic               updated_reg;

    // Combinational terms
    logic signed [16:0] err;
    logic signed [16:0] diff;
    logic signed [65:0] prod_mag;
    logic signed [32:0] deriv;
    logic signed [32:0] torque_mag;
    logic        [16:0] keep;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] product;
    logic signed [49:0] tq_sum;
    logic signed [44:0] inc;
    logic signed [49:0] vel_sum;
    logic signed [48:0] decay_biased;
    logic        [63:0] div_dividend;
    logic        [31:0] div_divisor;
    logic [DIV_PAIRS_W-1:0] div_pairs;
    logic               div_busy;
    logic        [63:0] div_quot;

    // Operand preparation
    always_comb
    begin
        err        = {angle_reg[15], angle_reg} - {angle_setpoint_reg[15], angle_setpoint_reg};
        diff       = {angle_reg[15], angle_reg} - {prev_angle_reg[15], prev_angle_reg};
        prod_mag   = prod_reg[65] ? -prod_reg : prod_reg;
        deriv      = prod_reg[65] ? -$signed({2'b00, div_quot[30:0]})
                                  :  $signed({2'b00, div_quot[30:0]});
        torque_mag = torque_reg[31] ? -{torque_reg[31], torque_reg}
                                    :  {torque_reg[31], torque_reg};
        keep       = 17'h10000 - {1'b0, decay_fraction_reg};
    end

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_op)
            MUL_PROP:
            begin
                mul_a = {{17{prop_gain_reg[15]}}, prop_gain_reg};
                mul_b = {{16{err[16]}}, err};
            end
            MUL_DIFF:
            begin
                mul_a = {{16{diff[16]}}, diff};
                mul_b = {1'b0, US_PER_S};
            end
            MUL_DERIV:
            begin
                mul_a = {{17{deriv_gain_reg[15]}}, deriv_gain_reg};
                mul_b = deriv;
            end
            MUL_TORQUE:
            begin
                mul_a = torque_mag;
                mul_b = {1'b0, step_reg};
            end
            MUL_DECAY:
            begin
                mul_a = {vel_reg[31], vel_reg};
                mul_b = {16'd0, keep};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = mul_a * mul_b;
    end

    // Divider operand select
    always_comb
    begin
        case (cmd.div_op)
            DIV_RATE:
            begin
                div_dividend = {prod_mag[35:0], 28'd0};
                div_divisor  = step_reg;
                div_pairs    = RATE_PAIRS;
            end
            DIV_INC:
            begin
                div_dividend = prod_reg[63:0];
                div_divisor  = US_PER_S;
                div_pairs    = INC_PAIRS;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = US_PER_S;
                div_pairs    = '0;
            end
        endcase
    end

    pdwv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .pairs    (div_pairs),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Torque sum, increment and decay arithmetic
    always_comb
    begin
        tq_sum       = {{17{tq_p_reg[32]}}, tq_p_reg} + {prod_reg[48], prod_reg[48:0]};
        inc          = torque_reg[31] ? -$signed({1'b0, div_quot[43:0]})
                                      :  $signed({1'b0, div_quot[43:0]});
        vel_sum      = {{18{velocity_acc_reg[31]}}, velocity_acc_reg}
                     + {{5{inc[44]}}, inc};
        decay_biased = prod_reg[48:0] + (prod_reg[48] ? 49'sd65535 : 49'sd0);
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= '0;
            deriv_gain_reg     <= '0;
            decay_fraction_reg <= '0;
            angle_setpoint_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROP_GAIN:      prop_gain_reg      <= cfg_data;
                REG_DERIV_GAIN:     deriv_gain_reg     <= cfg_data;
                REG_DECAY_FRACTION: decay_fraction_reg <= cfg_data;
                REG_ANGLE_SETPOINT: angle_setpoint_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Controller state: advance only on an updating word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg   <= '0;
            prev_time_reg    <= '0;
            velocity_acc_reg <= '0;
            upd_reg          <= 1'b0;
        end
        else
        begin
            if (cmd.eval_step)
                upd_reg <= step_reg > MIN_STEP_US;
            if (cmd.commit)
            begin
                velocity_acc_reg <= decay_biased[47:16];
                prev_angle_reg   <= angle_reg;
                prev_time_reg    <= now_reg;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            angle_reg <= tilt_angle;
            now_reg   <= timestamp_us;
            step_reg  <= timestamp_us - prev_time_reg;
        end
        if (cmd.mul_op != MUL_NONE)
            prod_reg <= product;
        if (cmd.save_prop)
            tq_p_reg <= prod_reg[32:0];
        if (cmd.sum_torque)
            torque_reg <= sat32({tq_sum[48:0], 1'b0});
        if (cmd.acc_vel)
            vel_reg <= sat32(vel_sum);
        if (cmd.load_out)
        begin
            wheel_velocity_reg <= velocity_acc_reg;
            updated_reg        <= upd_reg;
        end
    end

    assign status.step_big = step_reg > MIN_STEP_US;
    assign status.div_busy = div_busy;
    assign wheel_velocity  = wheel_velocity_reg;
    assign updated         = updated_reg;

    `ASRT_ALWAYS(a_commit_on_update, cmd.commit |-> upd_reg, "state committed on a short step")

endmodule

@@ hw/rtl/pdwv_ctrl.sv @@
// ----------------------------------------------------------------------------
// PD controller sequencer
// Accepts input words, steps the datapath through the update and hands the
// result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdwv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output pdwv_pkg::cmd_t    cmd,
    input  pdwv_pkg::status_t status
);
    import pdwv_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.eval_step = 1'b1;
                state_next    = status.step_big ? ST_MUL_PROP : ST_DONE;
            end
            ST_MUL_PROP:
            begin
                cmd.mul_op = MUL_PROP;
                state_next = ST_MUL_DIFF;
            end
            ST_MUL_DIFF:
            begin
                cmd.mul_op    = MUL_DIFF;
                cmd.save_prop = 1'b1;
                state_next    = ST_DIV_RATE;
            end
            ST_DIV_RATE:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_RATE;
                state_next    = ST_WAIT_RATE;
            end
            ST_WAIT_RATE:
            begin
                if (!status.div_busy)
                    state_next = ST_MUL_DERIV;
            end
            ST_MUL_DERIV:
            begin
                cmd.mul_op = MUL_DERIV;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_torque = 1'b1;
                state_next     = ST_MUL_TORQUE;
            end
            ST_MUL_TORQUE:
            begin
                cmd.mul_op = MUL_TORQUE;
                state_next = ST_DIV_INC;
            end
            ST_DIV_INC:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_INC;
                state_next    = ST_WAIT_INC;
            end
            ST_WAIT_INC:
            begin
                cmd.div_op = DIV_INC;
                if (!status.div_busy)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.div_op  = DIV_INC;
                cmd.acc_vel = 1'b1;
                state_next  = ST_MUL_DECAY;
            end
            ST_MUL_DECAY:
            begin
                cmd.mul_op = MUL_DECAY;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid: set on load, drop once taken
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    `ASRT_ALWAYS(a_divider_waited, status.div_busy |-> (state_reg == ST_WAIT_RATE || state_reg == ST_WAIT_INC), "divider busy outside a wait state")
    `ASRT_ALWAYS(a_result_from_done, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE), "result word raised outside the done state")
    `ASRT_NEXT(a_taken_while_loading, cmd.load_out, out_valid_reg, "loaded result word not presented")

endmodule

@@ hw/rtl/pd_wheel_velocity_controller_top.sv @@
// ----------------------------------------------------------------------------
// PD wheel velocity controller
// Proportional-derivative torque from tilt angle and rate, integrated into a
// leaky, saturating wheel velocity.
// ----------------------------------------------------------------------------
// Each input word (tilt angle, microsecond timestamp) yields exactly one
// result word (wheel velocity, updated flag). A word whose step since the
// last update is 100 us or less returns the held velocity. An updating
// word holds in_stall until its result is loaded for presentation, and
// most of that time goes to the shared divider, which retires two
// quotient bits per cycle: 18 steps for the angle rate and 32 steps for
// the velocity increment, with the shared multiplier used around them.
// A new word is accepted while the previous result still waits on
// out_stall.
// Configuration writes are always ready and must only be issued while idle.
// ----------------------------------------------------------------------------
module pd_wheel_velocity_controller_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [15:0]               tilt_angle,
    input  logic [31:0]                      timestamp_us,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [31:0]               wheel_velocity,
    output logic                             updated,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pdwv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdwv_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pdwv_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    cfg_we;

    // Configuration writes are always accepted and never stall
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    pdwv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    pdwv_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .tilt_angle     (tilt_angle),
        .timestamp_us   (timestamp_us),
        .wheel_velocity (wheel_velocity),
        .updated        (updated)
    );

endmodule
